// ===== src/bankers_resource_grant_core_assert.svh =====
// Assertion macros used by the checker of the resource grant core.
`ifndef BANKERS_RESOURCE_GRANT_CORE_ASSERT_SVH
`define BANKERS_RESOURCE_GRANT_CORE_ASSERT_SVH

// Implication checked at every rising edge outside reset.
`define BRG_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that never holds outside reset.
`define BRG_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== src/brg_pkg.sv =====
// Shared widths, operation codes and status codes of the resource grant core.
package brg_pkg;

  localparam int OP_W       = 3;
  localparam int PROC_W     = 3;
  localparam int RES_W      = 2;
  localparam int AMT_W      = 8;
  localparam int STATUS_W   = 3;
  localparam int WORK_W     = 16;
  localparam int CFG_PROCS_W = 4;
  localparam int CFG_RES_W  = 3;
  localparam int FIELD_PROCS = 8;
  localparam int FIELD_RES  = 4;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [OP_W-1:0] OP_WR_ALLOC = 3'd0;
  localparam logic [OP_W-1:0] OP_WR_NEED  = 3'd1;
  localparam logic [OP_W-1:0] OP_WR_AVAIL = 3'd2;
  localparam logic [OP_W-1:0] OP_REQUEST  = 3'd3;
  localparam logic [OP_W-1:0] OP_QUERY    = 3'd4;

  localparam logic [STATUS_W-1:0] ST_GRANTED       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EXCEEDS_NEED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EXCEEDS_AVAIL = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ROLLED_BACK   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_SAFE          = 3'd4;
  localparam logic [STATUS_W-1:0] ST_UNSAFE        = 3'd5;

  localparam logic REG_ACTIVE_PROCS = 1'b0;
  localparam logic REG_ACTIVE_RES   = 1'b1;

  localparam logic [CFG_PROCS_W-1:0] RESET_PROCS = 4'd8;
  localparam logic [CFG_RES_W-1:0]   RESET_RES   = 3'd4;

endpackage

// ===== src/brg_cmd_if.sv =====
// Command channel carrying table writes, request elements and safety queries.
interface brg_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [brg_pkg::OP_W-1:0]    op;
  logic [brg_pkg::PROC_W-1:0]  process;
  logic [brg_pkg::RES_W-1:0]   resource;
  logic [brg_pkg::AMT_W-1:0]   amount;
  logic                        last;

  modport source(output valid, op, process, resource, amount, last, input ready);
  modport sink(input valid, op, process, resource, amount, last, output ready);
endinterface

// ===== src/brg_rsp_if.sv =====
// Result channel carrying grant status and the safe sequence.
interface brg_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [brg_pkg::STATUS_W-1:0]  status;
  logic [brg_pkg::PROC_W-1:0]    seq_process;
  logic                          last_res;

  modport source(output valid, status, seq_process, last_res, input ready);
  modport sink(input valid, status, seq_process, last_res, output ready);
endinterface

// ===== src/bankers_resource_grant_core.sv =====
// Banker's algorithm grant engine with tables held in synchronous memories.
//
//   Channel  Direction  Beat contents
//   cmd      in         op, process, resource, amount, last
//   rsp      out        status, seq_process, last_res
//   apb      in/out     active_procs at 0x0, active_resources at 0x4
//
// A table write is taken in S_IDLE. A request decision reads and checks the row
// (S_DEC_RD, S_DEC) before the scan; a query takes the scan alone. The scan reads
// each process row (S_RD) and tests it (S_EV), and restarts at process 0 after
// each fit. Results then leave one beat at a time (S_LOAD, S_OUT), each held until
// taken. Reset clears all tables. While results wait, no command is taken.
module bankers_resource_grant_core #(
  parameter int MAX_PROCS = 8,
  parameter int MAX_RES   = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [brg_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [brg_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [brg_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  brg_cmd_if.sink                          cmd,
  brg_rsp_if.source                        rsp
);

  localparam int PR = (MAX_PROCS < brg_pkg::FIELD_PROCS) ? MAX_PROCS : brg_pkg::FIELD_PROCS;
  localparam int RR = (MAX_RES < brg_pkg::FIELD_RES) ? MAX_RES : brg_pkg::FIELD_RES;
  localparam int PW = $clog2(PR);
  localparam int RW = (RR > 1) ? $clog2(RR) : 1;
  localparam int CW = $clog2(PR + 1);
  localparam int NW = $clog2(RR + 1);
  localparam int AW = brg_pkg::AMT_W;
  localparam int WW = brg_pkg::WORK_W;

  typedef enum logic [2:0] {S_IDLE, S_DEC_RD, S_DEC, S_RD, S_EV, S_LOAD, S_OUT} state_t;

  state_t state;

  logic [brg_pkg::CFG_PROCS_W-1:0] active_procs;
  logic [brg_pkg::CFG_RES_W-1:0]   active_resources;
  logic [CW-1:0] np;
  logic [NW-1:0] nr;

  logic [AW-1:0] alloc_mem [PR][RR];
  logic [AW-1:0] need_mem [PR][RR];
  logic [RR-1:0] ent_valid [PR];
  logic [RR-1:0] need_valid [PR];
  logic [AW-1:0] alloc_rd [RR];
  logic [AW-1:0] need_rd [RR];
  logic [RR-1:0] valid_rd;
  logic [RR-1:0] need_valid_rd;

  logic [AW-1:0] avail [RR];
  logic [AW-1:0] req_buf [RR];
  logic [AW-1:0] t_alloc [RR];
  logic [AW-1:0] t_need [RR];
  logic [AW-1:0] t_avail [RR];
  logic [WW-1:0] work [RR];
  logic [PR-1:0] fin;
  logic [PW-1:0] seq_buf [PR];
  logic [brg_pkg::PROC_W-1:0] p_reg;
  logic          use_trial;
  logic [PW-1:0] idx;
  logic [CW-1:0] cnt;
  logic [CW-1:0] emit_k;
  logic          single;
  logic [brg_pkg::STATUS_W-1:0] st_code;

  logic                        rsp_valid;
  logic [brg_pkg::STATUS_W-1:0] rsp_status;
  logic [brg_pkg::PROC_W-1:0]  rsp_seq;
  logic                        rsp_last;

  logic cmd_acc;
  logic p_ok;
  logic r_ok;
  logic [PW-1:0] cmd_p;
  logic [RW-1:0] cmd_r;

  logic [AW-1:0] alloc_row [RR];
  logic [AW-1:0] need_row [RR];
  logic [AW-1:0] ev_alloc [RR];
  logic [AW-1:0] ev_need [RR];
  logic [AW-1:0] c_alloc [RR];
  logic [AW-1:0] c_need [RR];
  logic [AW-1:0] c_avail [RR];
  logic [brg_pkg::STATUS_W-1:0] chk_status;
  logic          fits;
  logic          hit;
  logic          done_safe;

  logic          rd_en;
  logic [PW-1:0] rd_addr;
  logic [RR-1:0] wr_alloc_en;
  logic [RR-1:0] wr_need_en;
  logic [PW-1:0] wr_addr;
  logic [AW-1:0] wr_alloc_d [RR];
  logic [AW-1:0] wr_need_d [RR];

  assign pready = 1'b1;
  assign prdata = (paddr[2] == brg_pkg::REG_ACTIVE_PROCS)
                  ? brg_pkg::APB_DATA_W'(active_procs)
                  : brg_pkg::APB_DATA_W'(active_resources);

  always_comb begin
    if (active_procs == '0) begin
      np = CW'(1);
    end else if (active_procs > PR) begin
      np = CW'(PR);
    end else begin
      np = active_procs[CW-1:0];
    end
    if (active_resources == '0) begin
      nr = NW'(1);
    end else if (active_resources > RR) begin
      nr = NW'(RR);
    end else begin
      nr = active_resources[NW-1:0];
    end
  end

  assign cmd.ready = (state == S_IDLE);
  assign cmd_acc   = cmd.valid && cmd.ready;
  assign p_ok      = (cmd.process < PR);
  assign r_ok      = (cmd.resource < RR);
  assign cmd_p     = cmd.process[PW-1:0];
  assign cmd_r     = cmd.resource[RW-1:0];

  assign rsp.valid       = rsp_valid;
  assign rsp.status      = rsp_status;
  assign rsp.seq_process = rsp_seq;
  assign rsp.last_res    = rsp_last;

  // Row data with never-written entries reading as zero, and trial values.
  always_comb begin
    hit = use_trial && (idx == p_reg[PW-1:0]);
    for (int j = 0; j < RR; j++) begin
      alloc_row[j] = valid_rd[j] ? alloc_rd[j] : '0;
      need_row[j]  = need_valid_rd[j] ? need_rd[j] : '0;
      ev_alloc[j]  = hit ? t_alloc[j] : alloc_row[j];
      ev_need[j]   = hit ? t_need[j] : need_row[j];
    end
  end

  always_comb begin
    logic [AW:0] sum;
    chk_status = brg_pkg::ST_GRANTED;
    sum = '0;
    if (p_reg >= np) begin
      chk_status = brg_pkg::ST_EXCEEDS_NEED;
    end
    for (int j = 0; j < RR; j++) begin
      c_alloc[j] = alloc_row[j];
      c_need[j]  = need_row[j];
      c_avail[j] = avail[j];
      if (j < nr) begin
        if (chk_status == brg_pkg::ST_GRANTED) begin
          if (req_buf[j] > need_row[j]) begin
            chk_status = brg_pkg::ST_EXCEEDS_NEED;
          end else if (req_buf[j] > avail[j]) begin
            chk_status = brg_pkg::ST_EXCEEDS_AVAIL;
          end
        end
        sum = {1'b0, alloc_row[j]} + {1'b0, req_buf[j]};
        c_alloc[j] = sum[AW] ? {AW{1'b1}} : sum[AW-1:0];
        c_need[j]  = need_row[j] - req_buf[j];
        c_avail[j] = avail[j] - req_buf[j];
      end
    end
  end

  always_comb begin
    fits = !fin[idx];
    for (int j = 0; j < RR; j++) begin
      if ((j < nr) && ({{(WW-AW){1'b0}}, ev_need[j]} > work[j])) begin
        fits = 1'b0;
      end
    end
    done_safe = (state == S_EV) && fits && ((cnt + CW'(1)) == np);
  end

  assign rd_en   = (state == S_DEC_RD) || (state == S_RD);
  assign rd_addr = (state == S_DEC_RD) ? p_reg[PW-1:0] : idx;

  always_comb begin
    wr_alloc_en = '0;
    wr_need_en  = '0;
    wr_addr     = cmd_p;
    for (int j = 0; j < RR; j++) begin
      wr_alloc_d[j] = cmd.amount;
      wr_need_d[j]  = cmd.amount;
    end
    if (done_safe && use_trial) begin
      wr_alloc_en = '1;
      wr_need_en  = '1;
      wr_addr     = p_reg[PW-1:0];
      for (int j = 0; j < RR; j++) begin
        wr_alloc_d[j] = t_alloc[j];
        wr_need_d[j]  = t_need[j];
      end
    end else if (cmd_acc && p_ok && r_ok) begin
      if (cmd.op == brg_pkg::OP_WR_ALLOC) begin
        wr_alloc_en[cmd_r] = 1'b1;
      end else if (cmd.op == brg_pkg::OP_WR_NEED) begin
        wr_need_en[cmd_r] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < RR; j++) begin
      if (wr_alloc_en[j]) begin
        alloc_mem[wr_addr][j] <= wr_alloc_d[j];
      end
      if (wr_need_en[j]) begin
        need_mem[wr_addr][j] <= wr_need_d[j];
      end
    end
    if (rd_en) begin
      alloc_rd      <= alloc_mem[rd_addr];
      need_rd       <= need_mem[rd_addr];
      valid_rd      <= ent_valid[rd_addr];
      need_valid_rd <= need_valid[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      active_procs     <= brg_pkg::RESET_PROCS;
      active_resources <= brg_pkg::RESET_RES;
      rsp_valid        <= 1'b0;
      use_trial        <= 1'b0;
      single           <= 1'b0;
      fin              <= '0;
      idx              <= '0;
      cnt              <= '0;
      emit_k           <= '0;
      for (int p = 0; p < PR; p++) begin
        ent_valid[p]  <= '0;
        need_valid[p] <= '0;
      end
      for (int j = 0; j < RR; j++) begin
        avail[j]   <= '0;
        req_buf[j] <= '0;
      end
    end else begin
      if (psel && penable && pwrite) begin
        if (paddr[2] == brg_pkg::REG_ACTIVE_PROCS) begin
          active_procs <= pwdata[brg_pkg::CFG_PROCS_W-1:0];
        end else begin
          active_resources <= pwdata[brg_pkg::CFG_RES_W-1:0];
        end
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_acc) begin
            if ((cmd.op == brg_pkg::OP_WR_ALLOC) || (cmd.op == brg_pkg::OP_WR_NEED)) begin
              if (p_ok && r_ok) begin
                if (cmd.op == brg_pkg::OP_WR_ALLOC) begin
                  ent_valid[cmd_p][cmd_r] <= 1'b1;
                end else begin
                  need_valid[cmd_p][cmd_r] <= 1'b1;
                end
              end
            end else if (cmd.op == brg_pkg::OP_WR_AVAIL) begin
              if (r_ok) begin
                avail[cmd_r] <= cmd.amount;
              end
            end else if (cmd.op == brg_pkg::OP_REQUEST) begin
              if (r_ok) begin
                req_buf[cmd_r] <= cmd.amount;
              end
              if (cmd.last) begin
                p_reg <= cmd.process;
                state <= S_DEC_RD;
              end
            end else if (cmd.op == brg_pkg::OP_QUERY) begin
              use_trial <= 1'b0;
              fin       <= '0;
              idx       <= '0;
              cnt       <= '0;
              for (int j = 0; j < RR; j++) begin
                work[j] <= WW'(avail[j]);
              end
              state <= S_RD;
            end
          end
        end
        S_DEC_RD: begin
          state <= S_DEC;
        end
        S_DEC: begin
          for (int j = 0; j < RR; j++) begin
            req_buf[j] <= '0;
          end
          if (chk_status != brg_pkg::ST_GRANTED) begin
            st_code <= chk_status;
            single  <= 1'b1;
            emit_k  <= '0;
            state   <= S_LOAD;
          end else begin
            use_trial <= 1'b1;
            fin       <= '0;
            idx       <= '0;
            cnt       <= '0;
            for (int j = 0; j < RR; j++) begin
              t_alloc[j] <= c_alloc[j];
              t_need[j]  <= c_need[j];
              t_avail[j] <= c_avail[j];
              work[j]    <= WW'(c_avail[j]);
            end
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= S_EV;
        end
        S_EV: begin
          if (fits) begin
            for (int j = 0; j < RR; j++) begin
              if (j < nr) begin
                work[j] <= work[j] + WW'(ev_alloc[j]);
              end
            end
            fin[idx]                <= 1'b1;
            seq_buf[cnt[PW-1:0]]    <= idx;
            if (done_safe) begin
              if (use_trial) begin
                for (int j = 0; j < RR; j++) begin
                  avail[j] <= t_avail[j];
                end
                for (int j = 0; j < RR; j++) begin
                  ent_valid[p_reg[PW-1:0]][j]  <= 1'b1;
                  need_valid[p_reg[PW-1:0]][j] <= 1'b1;
                end
              end
              st_code <= use_trial ? brg_pkg::ST_GRANTED : brg_pkg::ST_SAFE;
              single  <= 1'b0;
              emit_k  <= '0;
              state   <= S_LOAD;
            end else begin
              cnt   <= cnt + CW'(1);
              idx   <= '0;
              state <= S_RD;
            end
          end else if ((CW'(idx) + CW'(1)) == np) begin
            st_code <= use_trial ? brg_pkg::ST_ROLLED_BACK : brg_pkg::ST_UNSAFE;
            single  <= 1'b1;
            emit_k  <= '0;
            state   <= S_LOAD;
          end else begin
            idx   <= idx + PW'(1);
            state <= S_RD;
          end
        end
        S_LOAD: begin
          rsp_valid  <= 1'b1;
          rsp_status <= st_code;
          rsp_seq    <= single ? '0 : brg_pkg::PROC_W'(seq_buf[emit_k[PW-1:0]]);
          rsp_last   <= single || ((emit_k + CW'(1)) == np);
          state      <= S_OUT;
        end
        S_OUT: begin
          if (rsp.ready) begin
            rsp_valid <= 1'b0;
            if (rsp_last) begin
              state <= S_IDLE;
            end else begin
              emit_k <= emit_k + CW'(1);
              state  <= S_LOAD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/brg_checker.sv =====
// Port-level checker for the resource grant core and its bind statement.
`include "bankers_resource_grant_core_assert.svh"

module brg_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          cmd_valid,
  input logic                          cmd_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [brg_pkg::STATUS_W-1:0]  rsp_status,
  input logic [brg_pkg::PROC_W-1:0]    rsp_seq,
  input logic                          rsp_last
);

  // Commands are never taken while a result beat is pending.
  `BRG_NEVER(a_no_cmd_during_rsp, clk, rst, cmd_ready && rsp_valid, "command taken during results")

  // A rejection or an unsafe outcome is a single beat with no sequence.
  `BRG_ASSERT(a_reject_single, clk, rst, (rsp_valid && ((rsp_status == brg_pkg::ST_EXCEEDS_NEED) || (rsp_status == brg_pkg::ST_EXCEEDS_AVAIL) || (rsp_status == brg_pkg::ST_ROLLED_BACK) || (rsp_status == brg_pkg::ST_UNSAFE))) |-> (rsp_last && (rsp_seq == '0)), "rejection not a single beat")

  // The final beat of a run frees the block for the next command.
  `BRG_ASSERT(a_last_frees, clk, rst, (rsp_valid && rsp_ready && rsp_last) |=> (cmd_ready && !rsp_valid), "block not idle after last beat")

  // A stalled beat holds its contents.
  `BRG_ASSERT(a_stall_hold, clk, rst, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status) && $stable(rsp_seq) && $stable(rsp_last)), "stalled beat changed")

endmodule

bind bankers_resource_grant_core brg_checker u_brg_checker (
  .clk        (clk),
  .rst        (rst),
  .cmd_valid  (cmd.valid),
  .cmd_ready  (cmd.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_status (rsp.status),
  .rsp_seq    (rsp.seq_process),
  .rsp_last   (rsp.last_res)
);

// ===== tb/sv/brg_grant_ledger.sv =====
// Scoreboard class that predicts the resource grant core and checks its result beats.
class brg_grant_ledger;
  typedef struct packed {
    logic [2:0] status;
    logic [2:0] seq_process;
    logic       last_res;
  } grant_beat_t;

  logic [3:0] procs_reg;
  logic [2:0] res_reg;
  logic [7:0] avail[4];
  logic [7:0] alloc[32];
  logic [7:0] need[32];
  logic [7:0] req_buf[4];
  grant_beat_t pending[$];
  int mismatches;
  int beats_seen;
  int grants;
  int rejects;
  int queries;

  function new();
    procs_reg = brg_pkg::RESET_PROCS;
    res_reg = brg_pkg::RESET_RES;
    foreach (avail[j]) avail[j] = '0;
    foreach (alloc[k]) begin
      alloc[k] = '0;
      need[k] = '0;
    end
    foreach (req_buf[j]) req_buf[j] = '0;
    mismatches = 0;
    beats_seen = 0;
    grants = 0;
    rejects = 0;
    queries = 0;
  endfunction

  function void set_reg(logic idx, logic [31:0] val);
    if (idx == brg_pkg::REG_ACTIVE_PROCS) procs_reg = val[3:0];
    else res_reg = val[2:0];
  endfunction

  function int proc_count();
    if (procs_reg < 1) return 1;
    if (procs_reg > 8) return 8;
    return procs_reg;
  endfunction

  function int res_count();
    if (res_reg < 1) return 1;
    if (res_reg > 4) return 4;
    return res_reg;
  endfunction

  function bit safety_scan(logic [7:0] av[4], logic [7:0] al[32], logic [7:0] nd[32],
                           int np, int nr, ref logic [2:0] order[8]);
    logic [15:0] work[4];
    bit fin[8];
    int done;
    bit found;
    bit fits;
    done = 0;
    foreach (fin[i]) fin[i] = 0;
    for (int j = 0; j < 4; j++) work[j] = av[j];
    while (done < np) begin
      found = 0;
      for (int i = 0; i < np && !found; i++) begin
        fits = !fin[i];
        for (int j = 0; j < nr && fits; j++)
          if (nd[i*4+j] > work[j]) fits = 0;
        if (fits) begin
          for (int j = 0; j < nr; j++) work[j] = work[j] + al[i*4+j];
          fin[i] = 1;
          order[done] = i[2:0];
          done++;
          found = 1;
        end
      end
      if (!found) break;
    end
    return done == np;
  endfunction

  function void push_single(logic [2:0] st);
    grant_beat_t b;
    b.status = st;
    b.seq_process = '0;
    b.last_res = 1'b1;
    pending.push_back(b);
  endfunction

  function void push_order(logic [2:0] st, logic [2:0] order[8], int np);
    grant_beat_t b;
    for (int k = 0; k < np; k++) begin
      b.status = st;
      b.seq_process = order[k];
      b.last_res = (k == np - 1);
      pending.push_back(b);
    end
  endfunction

  function void note_command(logic [2:0] op, logic [2:0] p, logic [1:0] r,
                             logic [7:0] amt, logic lst);
    int np;
    int nr;
    logic [2:0] st;
    logic [2:0] order[8];
    logic [7:0] av[4];
    logic [7:0] al[32];
    logic [7:0] nd[32];
    int a;
    np = proc_count();
    nr = res_count();
    case (op)
      brg_pkg::OP_WR_ALLOC: alloc[p*4+r] = amt;
      brg_pkg::OP_WR_NEED:  need[p*4+r] = amt;
      brg_pkg::OP_WR_AVAIL: avail[r] = amt;
      brg_pkg::OP_REQUEST: begin
        req_buf[r] = amt;
        if (lst) begin
          st = brg_pkg::ST_GRANTED;
          if (p >= np) st = brg_pkg::ST_EXCEEDS_NEED;
          else begin
            for (int j = 0; j < nr && st == brg_pkg::ST_GRANTED; j++) begin
              if (req_buf[j] > need[p*4+j]) st = brg_pkg::ST_EXCEEDS_NEED;
              else if (req_buf[j] > avail[j]) st = brg_pkg::ST_EXCEEDS_AVAIL;
            end
          end
          if (st != brg_pkg::ST_GRANTED) begin
            rejects++;
            push_single(st);
          end else begin
            av = avail;
            al = alloc;
            nd = need;
            for (int j = 0; j < nr; j++) begin
              a = al[p*4+j] + req_buf[j];
              av[j] = av[j] - req_buf[j];
              al[p*4+j] = (a > 255) ? 8'd255 : a[7:0];
              nd[p*4+j] = nd[p*4+j] - req_buf[j];
            end
            if (!safety_scan(av, al, nd, np, nr, order)) begin
              rejects++;
              push_single(brg_pkg::ST_ROLLED_BACK);
            end else begin
              grants++;
              avail = av;
              alloc = al;
              need = nd;
              push_order(brg_pkg::ST_GRANTED, order, np);
            end
          end
          foreach (req_buf[j]) req_buf[j] = '0;
        end
      end
      brg_pkg::OP_QUERY: begin
        queries++;
        if (!safety_scan(avail, alloc, need, np, nr, order)) push_single(brg_pkg::ST_UNSAFE);
        else push_order(brg_pkg::ST_SAFE, order, np);
      end
      default: ;
    endcase
  endfunction

  function void check_beat(logic [2:0] st, logic [2:0] sp, logic lr);
    grant_beat_t e;
    beats_seen++;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected beat: status %0d seq %0d last %0d", st, sp, lr);
      return;
    end
    e = pending.pop_front();
    if (e.status !== st || e.seq_process !== sp || e.last_res !== lr) begin
      mismatches++;
      if (mismatches <= 10)
        $display("beat mismatch: expected status %0d seq %0d last %0d, got %0d %0d %0d",
                 e.status, e.seq_process, e.last_res, st, sp, lr);
    end
  endfunction
endclass

// ===== tb/sv/bankers_resource_grant_core_test.sv =====
// Testbench top that drives the resource grant core and checks every result beat.
module bankers_resource_grant_core_test;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [brg_pkg::APB_ADDR_W-1:0] paddr = '0;
  logic [brg_pkg::APB_DATA_W-1:0] pwdata = '0;
  logic [brg_pkg::APB_DATA_W-1:0] prdata;
  logic pready;
  int idle_cycles = 0;
  bit hold_off = 0;
  bit drain_done = 0;

  brg_cmd_if cmd ();
  brg_rsp_if rsp ();
  brg_grant_ledger ledger = new();

  bankers_resource_grant_core uut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .cmd(cmd.sink), .rsp(rsp.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    cmd.valid = 1'b0;
    cmd.op = '0;
    cmd.process = '0;
    cmd.resource = '0;
    cmd.amount = '0;
    cmd.last = 1'b0;
    rsp.ready = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready)
      ledger.check_beat(rsp.status, rsp.seq_process, rsp.last_res);
    if (!rst && ((rsp.valid && rsp.ready) || (cmd.valid && cmd.ready) || (psel && penable)))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk) begin
    if (rst || hold_off) rsp.ready <= 1'b0;
    else if (drain_done) rsp.ready <= 1'b1;
    else if (($urandom_range(0, 63) < 24) && ($urandom_range(0, 3) != 0)) rsp.ready <= 1'b0;
    else rsp.ready <= ($urandom_range(0, 5) != 0);
  end

  always @(posedge clk) begin
    if (idle_cycles > 20000) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic write_reg(logic idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    ledger.set_reg(idx, val);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_command(logic [2:0] op, logic [2:0] p, logic [1:0] r,
                              logic [7:0] amt, logic lst);
    cmd.valid <= 1'b1;
    cmd.op <= op;
    cmd.process <= p;
    cmd.resource <= r;
    cmd.amount <= amt;
    cmd.last <= lst;
    do @(posedge clk); while (!cmd.ready);
    ledger.note_command(op, p, r, amt, lst);
  endtask

  task automatic pause_sender();
    int gap;
    if ($urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      cmd.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle();
    cmd.valid <= 1'b0;
    @(posedge clk);
    while (ledger.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic load_tables(int np, int nr, int scale);
    for (int i = 0; i < np; i++)
      for (int j = 0; j < nr; j++) begin
        send_command(brg_pkg::OP_WR_ALLOC, i, j, $urandom_range(0, scale), 1'b0);
        pause_sender();
        send_command(brg_pkg::OP_WR_NEED, i, j, $urandom_range(0, scale), 1'b0);
        pause_sender();
      end
    for (int j = 0; j < nr; j++)
      send_command(brg_pkg::OP_WR_AVAIL, 0, j, $urandom_range(0, scale + 4), 1'b0);
  endtask

  task automatic random_request(int np, int nr);
    int p;
    int k;
    p = $urandom_range(0, 7);
    if ($urandom_range(0, 5) != 0) p = $urandom_range(0, np - 1);
    k = $urandom_range(1, nr);
    for (int j = 0; j < k; j++) begin
      send_command(brg_pkg::OP_REQUEST, p, j,
                   ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                               : $urandom_range(0, 3),
                   j == k - 1);
      pause_sender();
    end
  endtask

  initial begin
    int cfg_p[6];
    int cfg_r[6];
    cfg_p = '{8, 1, 3, 0, 15, 5};
    cfg_r = '{4, 1, 2, 0, 7, 3};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    send_command(brg_pkg::OP_QUERY, 0, 0, 0, 1'b0);
    send_command(brg_pkg::OP_REQUEST, 0, 0, 8'd1, 1'b1);
    send_command(brg_pkg::OP_WR_AVAIL, 7, 3, 8'd255, 1'b0);
    send_command(brg_pkg::OP_WR_AVAIL, 0, 0, 8'd255, 1'b0);
    send_command(brg_pkg::OP_WR_NEED, 7, 3, 8'd255, 1'b0);
    send_command(brg_pkg::OP_WR_NEED, 2, 0, 8'd2, 1'b0);
    send_command(brg_pkg::OP_WR_ALLOC, 2, 0, 8'd255, 1'b0);
    send_command(brg_pkg::OP_REQUEST, 2, 0, 8'd2, 1'b1);
    send_command(brg_pkg::OP_REQUEST, 7, 3, 8'd255, 1'b1);
    send_command(brg_pkg::OP_REQUEST, 7, 3, 8'd200, 1'b1);
    send_command(brg_pkg::OP_WR_NEED, 1, 1, 8'd9, 1'b0);
    send_command(brg_pkg::OP_REQUEST, 1, 1, 8'd5, 1'b1);
    send_command(brg_pkg::OP_REQUEST, 1, 0, 8'd1, 1'b1);
    send_command(brg_pkg::OP_QUERY, 0, 0, 0, 1'b1);
    send_command(3'd5, 7, 3, 8'd255, 1'b1);
    send_command(3'd6, 0, 0, 0, 1'b0);
    send_command(3'd7, 0, 0, 0, 1'b0);
    settle();
    for (int ph = 0; ph < 6; ph++) begin
      int np;
      int nr;
      write_reg(brg_pkg::REG_ACTIVE_PROCS, cfg_p[ph]);
      write_reg(brg_pkg::REG_ACTIVE_RES, cfg_r[ph]);
      np = ledger.proc_count();
      nr = ledger.res_count();
      load_tables(np, nr, (ph % 2) ? 255 : 6);
      if (ph == 2) begin
        fork
          begin
            hold_off = 1;
            repeat (400) @(posedge clk);
            hold_off = 0;
          end
          begin
            repeat (8) send_command(brg_pkg::OP_QUERY, 0, 0, 0, 1'b0);
          end
        join
      end
      for (int n = 0; n < 20; n++) begin
        case ($urandom_range(0, 5))
          0: send_command(brg_pkg::OP_QUERY, $urandom, $urandom, $urandom, $urandom);
          1: send_command($urandom_range(5, 7), $urandom, $urandom, $urandom, $urandom);
          2: send_command($urandom_range(0, 2), $urandom_range(0, 7), $urandom_range(0, 3),
                          $urandom_range(0, 255), 1'b0);
          default: random_request(np, nr);
        endcase
        pause_sender();
      end
      settle();
    end
    drain_done = 1;
    settle();
    $display("Covered %0d granted requests, %0d rejected or rolled back, %0d queries,",
             ledger.grants, ledger.rejects, ledger.queries);
    $display("%0d result beats checked over six register settings.", ledger.beats_seen);
    if (ledger.mismatches == 0 && ledger.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// ===== bankers_resource_grant_core.f =====
+incdir+src
src/brg_pkg.sv
src/brg_cmd_if.sv
src/brg_rsp_if.sv
src/bankers_resource_grant_core.sv
src/brg_checker.sv
tb/sv/brg_grant_ledger.sv
tb/sv/bankers_resource_grant_core_test.sv
